@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ src/pidpc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidpc_pkg
// Types, widths and codes shared by the PID position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidpc_pkg;

    localparam int INTEGRAL_BITS_DEF  = 48;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int TIME_FRAC_BITS = 16;
    localparam int FLD_W          = 16;
    localparam int NUM_IN_FIELDS  = 5;
    localparam int S_DATA_W       = FLD_W * NUM_IN_FIELDS;
    localparam int ERR_W          = FLD_W + 1;
    localparam int GAIN_W         = 32;
    localparam int CMD_W          = 8;
    localparam int CEIL_W         = 7;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int MUL_A_W        = 32;
    localparam int MUL_B_W        = 33;
    localparam int PROD_W         = MUL_A_W + MUL_B_W;
    localparam int DELTA_W        = 33;
    localparam int SPLIT_W        = 32;
    localparam int INTEG_EXT_W    = 2 * SPLIT_W;

    localparam logic [FLD_W-1:0] FOLD_SPAN  = 16'hFFFF;
    localparam logic [FLD_W-1:0] FOLD_START = 16'h7FFF;

    localparam logic [CMD_W-1:0]  FLOOR_RST = 8'h80;
    localparam logic [CEIL_W-1:0] CEIL_RST  = 7'h7F;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_INTEG,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_ACC_LAST,
        ST_ROUND,
        ST_TRUNC,
        ST_CLAMP
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MUL_DELTA,
        MUL_P,
        MUL_D,
        MUL_ILO,
        MUL_IHI
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     mul_en;
        logic     integ_en;
        logic     acc_en;
        logic     round_en;
        logic     trunc_en;
        logic     out_load;
    } dp_cmd_t;

endpackage

@@ src/pidpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pidpc_ctrl
// Sequencer for one controller update and the output beat handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pidpc_ctrl
    import pidpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.mul_sel    = MUL_DELTA;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                cmd.mul_sel = MUL_DELTA;
                cmd.mul_en  = 1'b1;
                state_next  = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.integ_en = 1'b1;
                state_next   = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_sel = MUL_P;
                cmd.mul_en  = 1'b1;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_sel = MUL_D;
                cmd.mul_en  = 1'b1;
                cmd.acc_en  = 1'b1;
                state_next  = ST_MUL_ILO;
            end
            ST_MUL_ILO:
            begin
                cmd.mul_sel = MUL_ILO;
                cmd.mul_en  = 1'b1;
                cmd.acc_en  = 1'b1;
                state_next  = ST_MUL_IHI;
            end
            ST_MUL_IHI:
            begin
                cmd.mul_sel = MUL_IHI;
                cmd.mul_en  = 1'b1;
                cmd.acc_en  = 1'b1;
                state_next  = ST_ACC_LAST;
            end
            ST_ACC_LAST:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_TRUNC;
            end
            ST_TRUNC:
            begin
                cmd.trunc_en = 1'b1;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a pending beat is never overwritten
    `ASSERT_NEVER(a_no_out_overrun, clk, rst_n, cmd.out_load && m_tvalid && !m_tready)
    // no second beat taken while an update is in flight
    `ASSERT_PROP(a_single_item, clk, rst_n, accept |=> !s_tready)
    // fixed schedule from accept to the clamp step
    `ASSERT_PROP(a_schedule, clk, rst_n, accept |-> ##10 (state_reg == ST_CLAMP))

endmodule

@@ src/pidpc_datapath.sv @@
// ----------------------------------------------------------------------------
// pidpc_datapath
// Registers, shared multiplier, saturating integral and output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidpc_datapath
    import pidpc_pkg::*;
#(
    parameter int INTEGRAL_BITS  = INTEGRAL_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  dp_cmd_t               cmd,
    output logic [CMD_W-1:0]      command
);

    localparam int SHIFT_TOTAL = GAIN_FRAC_BITS + TIME_FRAC_BITS;
    localparam int ACC_W       = INTEGRAL_BITS + 34;
    localparam int QW          = ACC_W - SHIFT_TOTAL + 1;
    localparam int SUM_W       = ((INTEGRAL_BITS > DELTA_W) ? INTEGRAL_BITS : DELTA_W) + 1;

    // configuration
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic signed [CMD_W-1:0]  floor_reg;
    logic        [CEIL_W-1:0] ceil_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            floor_reg  <= FLOOR_RST;
            ceil_reg   <= CEIL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_P:  gain_p_reg <= cfg_data;
                CFG_GAIN_I:  gain_i_reg <= cfg_data;
                CFG_GAIN_D:  gain_d_reg <= cfg_data;
                CFG_FLOOR:   floor_reg  <= cfg_data[CMD_W-1:0];
                CFG_CEILING: ceil_reg   <= cfg_data[CEIL_W-1:0];
                default:     ;
            endcase
        end
    end

    // input fields and folded position error
    logic        [FLD_W-1:0] goal_position;
    logic signed [FLD_W-1:0] goal_speed;
    logic        [FLD_W-1:0] current_position;
    logic signed [FLD_W-1:0] current_speed;
    logic        [FLD_W-1:0] elapsed;
    logic signed [ERR_W-1:0] diff;
    logic        [FLD_W-1:0] mag;
    logic signed [ERR_W-1:0] fold;
    logic signed [ERR_W-1:0] err_in;
    logic signed [ERR_W-1:0] deriv_in;

    assign goal_position    = s_tdata[0*FLD_W +: FLD_W];
    assign goal_speed       = s_tdata[1*FLD_W +: FLD_W];
    assign current_position = s_tdata[2*FLD_W +: FLD_W];
    assign current_speed    = s_tdata[3*FLD_W +: FLD_W];
    assign elapsed          = s_tdata[4*FLD_W +: FLD_W];

    always_comb
    begin
        diff = signed'({1'b0, goal_position}) - signed'({1'b0, current_position});
        mag  = diff[ERR_W-1] ? FLD_W'(-diff) : FLD_W'(diff);
        fold = signed'(ERR_W'(FOLD_SPAN - mag));
        if (mag >= FOLD_START)
        begin
            err_in = diff[ERR_W-1] ? fold : -fold;
        end
        else
        begin
            err_in = diff;
        end
        deriv_in = ERR_W'(goal_speed) - ERR_W'(current_speed);
    end

    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] deriv_reg;
    logic        [FLD_W-1:0] dt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg   <= err_in;
            deriv_reg <= deriv_in;
            dt_reg    <= elapsed;
        end
    end

    // shared multiplier
    logic signed [INTEGRAL_BITS-1:0] integ_reg;
    logic signed [INTEGRAL_BITS-1:0] integ_next;
    logic signed [INTEG_EXT_W-1:0]   integ_ext;
    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [MUL_B_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]        mul_out;
    logic signed [PROD_W-1:0]        prod_reg;
    mul_sel_t                        prod_kind_reg;

    assign integ_ext = INTEG_EXT_W'(integ_reg);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DELTA:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = signed'(MUL_B_W'(dt_reg));
            end
            MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = MUL_B_W'(err_reg);
            end
            MUL_D:
            begin
                mul_a = gain_d_reg;
                mul_b = MUL_B_W'(deriv_reg);
            end
            MUL_ILO:
            begin
                mul_a = gain_i_reg;
                mul_b = signed'(MUL_B_W'(integ_ext[SPLIT_W-1:0]));
            end
            MUL_IHI:
            begin
                mul_a = gain_i_reg;
                mul_b = MUL_B_W'(signed'(integ_ext[INTEG_EXT_W-1:SPLIT_W]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_out = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg      <= mul_out;
            prod_kind_reg <= cmd.mul_sel;
        end
    end

    // saturating integral, delta taken from the product register
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   integ_sum;

    always_comb
    begin
        delta     = prod_reg[DELTA_W-1:0];
        integ_sum = SUM_W'(integ_reg) + SUM_W'(delta);
        if (integ_sum != SUM_W'(signed'(integ_sum[INTEGRAL_BITS-1:0])))
        begin
            integ_next = integ_sum[SUM_W-1] ? {1'b1, {(INTEGRAL_BITS-1){1'b0}}}
                                            : {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[INTEGRAL_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (cmd.integ_en)
        begin
            integ_reg <= integ_next;
        end
    end

    // accumulator, rounding and truncation toward zero
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] addend;
    logic signed [QW-1:0]    q_reg;
    logic signed [QW-1:0]    q_floor;
    logic                    q_adj;

    always_comb
    begin
        case (prod_kind_reg)
            MUL_P, MUL_D: addend = ACC_W'(prod_reg) <<< TIME_FRAC_BITS;
            MUL_IHI:      addend = ACC_W'(prod_reg) <<< SPLIT_W;
            default:      addend = ACC_W'(prod_reg);
        endcase
        q_floor = QW'(signed'(acc_reg[ACC_W-1:SHIFT_TOTAL]));
        q_adj   = acc_reg[ACC_W-1] & (|acc_reg[SHIFT_TOTAL-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + addend;
        end
        else if (cmd.round_en)
        begin
            acc_reg <= acc_reg + (ACC_W'(1) <<< (SHIFT_TOTAL - 1));
        end
        if (cmd.trunc_en)
        begin
            q_reg <= q_floor + signed'(QW'(q_adj));
        end
    end

    // floor first, ceiling second
    logic signed [QW-1:0]    floor_ext;
    logic signed [QW-1:0]    ceil_ext;
    logic signed [QW-1:0]    lo_val;
    logic        [CMD_W-1:0] cmd_next;
    logic        [CMD_W-1:0] command_reg;

    always_comb
    begin
        floor_ext = QW'(floor_reg);
        ceil_ext  = signed'(QW'(ceil_reg));
        lo_val    = (q_reg < floor_ext) ? floor_ext : q_reg;
        cmd_next  = (lo_val > ceil_ext) ? CMD_W'(ceil_reg) : lo_val[CMD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            command_reg <= cmd_next;
        end
    end

    assign command = command_reg;

endmodule

@@ src/pid_position_controller.sv @@
// ----------------------------------------------------------------------------
// pid_position_controller
// Fixed-point PID position controller for a wrapping 16-bit encoder.
// ----------------------------------------------------------------------------
// m_tvalid is registered and rises when the clamp step loads the command.
// Updates run one at a time; the single shared 32x33 multiplier
// runs five times per update, followed by round, truncate and clamp steps.
// A finished command waits in the output register while the next beat is taken.
// Reset: integral cleared, gains zero, command limits -128 and 127.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_position_controller
    import pidpc_pkg::*;
#(
    parameter int INTEGRAL_BITS  = INTEGRAL_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // goal_position, goal_speed, current_position, current_speed, elapsed
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // command
    output logic [CMD_W-1:0]      m_tdata
);

    dp_cmd_t cmd;

    pidpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pidpc_datapath #(
        .INTEGRAL_BITS  (INTEGRAL_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .command   (m_tdata)
    );

endmodule
